### rtl/obbot_pkg.sv
// ----------------------------------------------------------------------------
// obbot_pkg
// Shared widths, register codes and stage bundles for the oriented-box
// overlap test.
// ----------------------------------------------------------------------------
package obbot_pkg;

   localparam int AXIS_W    = 16;
   localparam int AXIS_FRAC = AXIS_W - 2;
   localparam int COORD_W   = 20;
   localparam int EXT_W     = 16;
   localparam int SLACK_W   = 14;

   localparam int VEC_A = 3 * AXIS_W;
   localparam int VEC_C = 3 * COORD_W;
   localparam int VEC_E = 3 * EXT_W;

   // datapath widths, all exact
   localparam int D_W    = COORD_W + 1;
   localparam int PAB_W  = 2 * AXIS_W;
   localparam int R_W    = 2 * AXIS_W + 2;
   localparam int RMAG_W = R_W - 1;
   localparam int PDT_W  = D_W + AXIS_W;
   localparam int T_W    = PDT_W + 2;
   localparam int TL_W   = T_W / 2;
   localparam int TH_W   = T_W - TL_W;
   localparam int PH_W   = TH_W + R_W;
   localparam int PL_W   = TL_W + 1 + R_W;
   localparam int TR_W   = T_W + R_W;
   localparam int S_W    = TR_W + 2;
   localparam int PE_W   = EXT_W + RMAG_W;
   localparam int PS_W   = EXT_W + SLACK_W;
   localparam int CMP_W  = S_W + SLACK_W + EXT_W + 4;

   localparam int NUM_AXES = 15;
   localparam int LATENCY  = 8;

   localparam int CSR_AW = 6;
   localparam int CSR_DW = 64;

   typedef enum logic [2:0] {
      REG_AXIS_X = 3'd0,
      REG_AXIS_Y = 3'd1,
      REG_AXIS_Z = 3'd2,
      REG_CENTER = 3'd3,
      REG_HALF   = 3'd4,
      REG_SLACK  = 3'd5
   } csr_reg_type;

   localparam logic [VEC_A-1:0]   AXIS_ONE    = VEC_A'(1) << AXIS_FRAC;
   localparam logic [VEC_A-1:0]   RST_AXIS_X  = AXIS_ONE;
   localparam logic [VEC_A-1:0]   RST_AXIS_Y  = AXIS_ONE << AXIS_W;
   localparam logic [VEC_A-1:0]   RST_AXIS_Z  = AXIS_ONE << (2 * AXIS_W);
   localparam logic [SLACK_W-1:0] RST_SLACK   = SLACK_W'(16);

   typedef struct packed {
      logic [VEC_A-1:0]   axis_x;
      logic [VEC_A-1:0]   axis_y;
      logic [VEC_A-1:0]   axis_z;
      logic [VEC_C-1:0]   center;
      logic [VEC_E-1:0]   half_size;
      logic [SLACK_W-1:0] slack;
   } ref_box_type;

   // rotation stage output: t, r and all extent * |r| products
   typedef struct packed {
      logic                             valid;
      logic [2:0][T_W-1:0]              t;
      logic [2:0][2:0][R_W-1:0]         r;
      logic [2:0][2:0][2:0][PE_W-1:0]   pea;
      logic [2:0][2:0][2:0][PE_W-1:0]   peb;
      logic [2:0][PS_W-1:0]             psa;
      logic [2:0][PS_W-1:0]             psb;
      logic [VEC_E-1:0]                 cand_half;
   } rot_type;

   function automatic logic signed [AXIS_W-1:0] axis_comp(input logic [VEC_A-1:0] v,
                                                          input int k);
      return $signed(v[k*AXIS_W +: AXIS_W]);
   endfunction

   function automatic logic signed [COORD_W-1:0] coord_comp(input logic [VEC_C-1:0] v,
                                                            input int k);
      return $signed(v[k*COORD_W +: COORD_W]);
   endfunction

   function automatic logic [EXT_W-1:0] ext_comp(input logic [VEC_E-1:0] v, input int k);
      return v[k*EXT_W +: EXT_W];
   endfunction

endpackage

### rtl/obb_obb_overlap_test_top.sv
// ----------------------------------------------------------------------------
// obb_obb_overlap_test_top
// Oriented-box overlap test by separating axes against a reference box.
// ----------------------------------------------------------------------------
// One candidate box is taken per clock; busy never rises, so a command can be
// issued every cycle. rsp_valid pulses once for each box taken, with
// rsp_overlaps for that box, in command order. Each box passes through eight
// register stages in order: products of the axes, rotation and translation
// sums, extent products, split t*r products, their recombination, projected
// distances, the per-axis compare and the final OR.
// Results cannot be held off. Write the reference registers only while no
// command is in flight.
module obb_obb_overlap_test_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [obbot_pkg::VEC_A-1:0]   req_cand_axis_x,
   input  logic [obbot_pkg::VEC_A-1:0]   req_cand_axis_y,
   input  logic [obbot_pkg::VEC_A-1:0]   req_cand_axis_z,
   input  logic [obbot_pkg::VEC_C-1:0]   req_cand_center,
   input  logic [obbot_pkg::VEC_E-1:0]   req_cand_half_size,
   output logic                          rsp_valid,
   output logic                          rsp_overlaps,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [obbot_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [obbot_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [obbot_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                          csr_pready
);
   import obbot_pkg::*;

   ref_box_type ref_box;
   rot_type     rot;
   logic        accept;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   obbot_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .ref_box     (ref_box)
   );

   obbot_rot u_rot (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (accept),
      .cand_axis_x    (req_cand_axis_x),
      .cand_axis_y    (req_cand_axis_y),
      .cand_axis_z    (req_cand_axis_z),
      .cand_center    (req_cand_center),
      .cand_half_size (req_cand_half_size),
      .ref_box        (ref_box),
      .rot            (rot)
   );

   obbot_axis u_axis (
      .clock        (clock),
      .reset        (reset),
      .rot          (rot),
      .ref_box      (ref_box),
      .rsp_valid    (rsp_valid),
      .rsp_overlaps (rsp_overlaps)
   );

endmodule

### rtl/obbot_csr.sv
// ----------------------------------------------------------------------------
// obbot_csr
// Register file holding the reference box and the epsilon.
// ----------------------------------------------------------------------------
module obbot_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [obbot_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [obbot_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [obbot_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                          csr_pready,
   output obbot_pkg::ref_box_type        ref_box
);
   import obbot_pkg::*;

   ref_box_type ref_ff;
   ref_box_type ref_in;
   csr_reg_type sel;
   logic        wr_en;

   assign sel        = csr_reg_type'(csr_paddr[5:3]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign ref_box    = ref_ff;

   always_comb begin
      ref_in = ref_ff;
      if (wr_en) begin
         case (sel)
            REG_AXIS_X: ref_in.axis_x    = csr_pwdata[VEC_A-1:0];
            REG_AXIS_Y: ref_in.axis_y    = csr_pwdata[VEC_A-1:0];
            REG_AXIS_Z: ref_in.axis_z    = csr_pwdata[VEC_A-1:0];
            REG_CENTER: ref_in.center    = csr_pwdata[VEC_C-1:0];
            REG_HALF:   ref_in.half_size = csr_pwdata[VEC_E-1:0];
            REG_SLACK:  ref_in.slack     = csr_pwdata[SLACK_W-1:0];
            default:    ref_in = ref_ff;
         endcase
      end
   end

   always_comb begin
      case (sel)
         REG_AXIS_X: csr_prdata = CSR_DW'(ref_ff.axis_x);
         REG_AXIS_Y: csr_prdata = CSR_DW'(ref_ff.axis_y);
         REG_AXIS_Z: csr_prdata = CSR_DW'(ref_ff.axis_z);
         REG_CENTER: csr_prdata = CSR_DW'(ref_ff.center);
         REG_HALF:   csr_prdata = CSR_DW'(ref_ff.half_size);
         REG_SLACK:  csr_prdata = CSR_DW'(ref_ff.slack);
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff.axis_x    <= RST_AXIS_X;
         ref_ff.axis_y    <= RST_AXIS_Y;
         ref_ff.axis_z    <= RST_AXIS_Z;
         ref_ff.center    <= '0;
         ref_ff.half_size <= '0;
         ref_ff.slack     <= RST_SLACK;
      end else begin
         ref_ff <= ref_in;
      end
   end

endmodule

### rtl/obbot_rot.sv
// ----------------------------------------------------------------------------
// obbot_rot
// Stages 1-3: rotation matrix r, translation t in reference frame and the
// extent * |r| products used by the projected radii.
// ----------------------------------------------------------------------------
module obbot_rot (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [obbot_pkg::VEC_A-1:0]  cand_axis_x,
   input  logic [obbot_pkg::VEC_A-1:0]  cand_axis_y,
   input  logic [obbot_pkg::VEC_A-1:0]  cand_axis_z,
   input  logic [obbot_pkg::VEC_C-1:0]  cand_center,
   input  logic [obbot_pkg::VEC_E-1:0]  cand_half_size,
   input  obbot_pkg::ref_box_type       ref_box,
   output obbot_pkg::rot_type           rot
);
   import obbot_pkg::*;

   logic [VEC_A-1:0] ref_word [3];
   logic [VEC_A-1:0] cand_word [3];

   assign ref_word[0]  = ref_box.axis_x;
   assign ref_word[1]  = ref_box.axis_y;
   assign ref_word[2]  = ref_box.axis_z;
   assign cand_word[0] = cand_axis_x;
   assign cand_word[1] = cand_axis_y;
   assign cand_word[2] = cand_axis_z;

   // stage 1: a*b products and centre difference
   logic                     v1_ff;
   logic signed [PAB_W-1:0]  pab_in [3][3][3];
   logic signed [PAB_W-1:0]  pab_ff [3][3][3];
   logic signed [D_W-1:0]    d_in [3];
   logic signed [D_W-1:0]    d_ff [3];
   logic [VEC_E-1:0]         half1_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
               pab_in[i][j][k] = PAB_W'(axis_comp(ref_word[i], k))
                               * PAB_W'(axis_comp(cand_word[j], k));
            end
         end
         d_in[i] = D_W'(coord_comp(cand_center, i)) - D_W'(coord_comp(ref_box.center, i));
      end
   end

   // stage 2: r sums, |r| and d*a products
   logic                     v2_ff;
   logic signed [R_W-1:0]    r_in [3][3];
   logic signed [R_W-1:0]    r2_ff [3][3];
   logic [RMAG_W-1:0]        rmag_in [3][3];
   logic [RMAG_W-1:0]        rmag_ff [3][3];
   logic signed [PDT_W-1:0]  pdt_in [3][3];
   logic signed [PDT_W-1:0]  pdt_ff [3][3];
   logic [VEC_E-1:0]         half2_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            r_in[i][j] = R_W'(pab_ff[i][j][0]) + R_W'(pab_ff[i][j][1])
                       + R_W'(pab_ff[i][j][2]);
            rmag_in[i][j] = r_in[i][j][R_W-1] ? RMAG_W'(-r_in[i][j]) : RMAG_W'(r_in[i][j]);
            pdt_in[i][j] = PDT_W'(d_ff[j]) * PDT_W'(axis_comp(ref_word[i], j));
         end
      end
   end

   // stage 3: t sums and extent products
   logic                     v3_ff;
   logic signed [T_W-1:0]    t_in [3];
   logic signed [T_W-1:0]    t_ff [3];
   logic signed [R_W-1:0]    r3_ff [3][3];
   logic [PE_W-1:0]          pea_in [3][3][3];
   logic [PE_W-1:0]          pea_ff [3][3][3];
   logic [PE_W-1:0]          peb_in [3][3][3];
   logic [PE_W-1:0]          peb_ff [3][3][3];
   logic [PS_W-1:0]          psa_in [3];
   logic [PS_W-1:0]          psa_ff [3];
   logic [PS_W-1:0]          psb_in [3];
   logic [PS_W-1:0]          psb_ff [3];
   logic [VEC_E-1:0]         half3_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         t_in[i] = T_W'(pdt_ff[i][0]) + T_W'(pdt_ff[i][1]) + T_W'(pdt_ff[i][2]);
         psa_in[i] = PS_W'(ext_comp(ref_box.half_size, i)) * PS_W'(ref_box.slack);
         psb_in[i] = PS_W'(ext_comp(half2_ff, i)) * PS_W'(ref_box.slack);
         for (int m = 0; m < 3; m++) begin
            for (int n = 0; n < 3; n++) begin
               // pea[m][n][x] = ea_m * |r_nx|, peb[x][m][n] = eb_m * |r_xn|
               pea_in[m][n][i] = PE_W'(ext_comp(ref_box.half_size, m)) * PE_W'(rmag_ff[n][i]);
               peb_in[i][m][n] = PE_W'(ext_comp(half2_ff, m)) * PE_W'(rmag_ff[i][n]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      pab_ff   <= pab_in;
      d_ff     <= d_in;
      half1_ff <= cand_half_size;
      r2_ff    <= r_in;
      rmag_ff  <= rmag_in;
      pdt_ff   <= pdt_in;
      half2_ff <= half1_ff;
      t_ff     <= t_in;
      r3_ff    <= r2_ff;
      pea_ff   <= pea_in;
      peb_ff   <= peb_in;
      psa_ff   <= psa_in;
      psb_ff   <= psb_in;
      half3_ff <= half2_ff;
   end

   always_comb begin
      rot.valid     = v3_ff;
      rot.cand_half = half3_ff;
      for (int i = 0; i < 3; i++) begin
         rot.t[i]   = t_ff[i];
         rot.psa[i] = psa_ff[i];
         rot.psb[i] = psb_ff[i];
         for (int j = 0; j < 3; j++) begin
            rot.r[i][j] = r3_ff[i][j];
            for (int k = 0; k < 3; k++) begin
               rot.pea[i][j][k] = pea_ff[i][j][k];
               rot.peb[i][j][k] = peb_ff[i][j][k];
            end
         end
      end
   end

endmodule

### rtl/obbot_axis.sv
// ----------------------------------------------------------------------------
// obbot_axis
// Stages 4-8: projected distances and radii for all 15 axes, the strict
// compare per axis and the final overlap flag.
// ----------------------------------------------------------------------------
module obbot_axis (
   input  logic                    clock,
   input  logic                    reset,
   input  obbot_pkg::rot_type      rot,
   input  obbot_pkg::ref_box_type  ref_box,
   output logic                    rsp_valid,
   output logic                    rsp_overlaps
);
   import obbot_pkg::*;

   localparam int SH_F    = AXIS_FRAC;
   localparam int SH_SL   = 3 * AXIS_FRAC - SLACK_W;
   localparam int SH_LONE = 3 * AXIS_FRAC;
   localparam int SH_RSL  = 2 * AXIS_FRAC;
   localparam int SH_RLN  = 2 * AXIS_FRAC + SLACK_W;
   localparam int SH_TL   = AXIS_FRAC + SLACK_W;

   // stage 4: split t*r partial products, radii, reference-axis distance
   logic                     v4_ff;
   logic signed [TH_W-1:0]   th [3];
   logic signed [TL_W:0]     tl [3];
   logic [T_W-1:0]           tmag [3];
   logic signed [PH_W-1:0]   ph_in [3][3][3];
   logic signed [PH_W-1:0]   ph_ff [3][3][3];
   logic signed [PL_W-1:0]   pl_in [3][3][3];
   logic signed [PL_W-1:0]   pl_ff [3][3][3];
   logic [CMP_W-1:0]         rhs_in [NUM_AXES];
   logic [CMP_W-1:0]         rhs4_ff [NUM_AXES];
   logic [CMP_W-1:0]         lhs_in [3];
   logic [CMP_W-1:0]         lhs4_ff [3];

   always_comb begin
      logic [CMP_W-1:0] sum_b_sl;
      logic [CMP_W-1:0] sum_a_sl;
      int i1;
      int i2;
      int j1;
      int j2;
      sum_b_sl = CMP_W'(rot.psb[0]) + CMP_W'(rot.psb[1]) + CMP_W'(rot.psb[2]);
      sum_a_sl = CMP_W'(rot.psa[0]) + CMP_W'(rot.psa[1]) + CMP_W'(rot.psa[2]);
      for (int k = 0; k < 3; k++) begin
         th[k]   = $signed(rot.t[k][T_W-1:TL_W]);
         tl[k]   = $signed({1'b0, rot.t[k][TL_W-1:0]});
         tmag[k] = rot.t[k][T_W-1] ? (~rot.t[k] + T_W'(1)) : rot.t[k];
         for (int m = 0; m < 3; m++) begin
            for (int j = 0; j < 3; j++) begin
               ph_in[k][m][j] = PH_W'(th[k]) * PH_W'($signed(rot.r[m][j]));
               pl_in[k][m][j] = PL_W'(tl[k]) * PL_W'($signed(rot.r[m][j]));
            end
         end
      end
      for (int i = 0; i < 3; i++) begin
         // reference axis i
         lhs_in[i] = CMP_W'(tmag[i]) << SH_TL;
         rhs_in[i] = ((CMP_W'(rot.peb[i][0][0]) + CMP_W'(rot.peb[i][1][1])
                     + CMP_W'(rot.peb[i][2][2])) << SLACK_W)
                   + (sum_b_sl << SH_RSL)
                   + (CMP_W'(ext_comp(ref_box.half_size, i)) << SH_RLN);
         // candidate axis i
         rhs_in[3+i] = ((CMP_W'(rot.pea[0][0][i]) + CMP_W'(rot.pea[1][1][i])
                       + CMP_W'(rot.pea[2][2][i])) << SH_F)
                     + (sum_a_sl << SH_SL)
                     + (CMP_W'(ext_comp(rot.cand_half, i)) << SH_LONE);
      end
      for (int i = 0; i < 3; i++) begin
         i1 = (i == 2) ? 0 : i + 1;
         i2 = (i == 0) ? 2 : i - 1;
         for (int j = 0; j < 3; j++) begin
            j1 = (j == 2) ? 0 : j + 1;
            j2 = (j == 0) ? 2 : j - 1;
            rhs_in[6+3*i+j] = ((CMP_W'(rot.pea[i1][i2][j]) + CMP_W'(rot.pea[i2][i1][j])
                              + CMP_W'(rot.peb[i][j1][j2]) + CMP_W'(rot.peb[i][j2][j1]))
                              << SH_F)
                            + ((CMP_W'(rot.psa[i1]) + CMP_W'(rot.psa[i2])
                              + CMP_W'(rot.psb[j1]) + CMP_W'(rot.psb[j2])) << SH_SL);
         end
      end
   end

   // stage 5: recombine t*r
   logic                     v5_ff;
   logic signed [TR_W-1:0]   tr_in [3][3][3];
   logic signed [TR_W-1:0]   tr_ff [3][3][3];
   logic [CMP_W-1:0]         rhs5_ff [NUM_AXES];
   logic [CMP_W-1:0]         lhs5_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int m = 0; m < 3; m++) begin
            for (int j = 0; j < 3; j++) begin
               tr_in[k][m][j] = (TR_W'(ph_ff[k][m][j]) <<< TL_W) + TR_W'(pl_ff[k][m][j]);
            end
         end
      end
   end

   // stage 6: signed projected distances, reference-axis compare
   logic                     v6_ff;
   logic signed [S_W-1:0]    s_in [12];
   logic signed [S_W-1:0]    s_ff [12];
   logic [CMP_W-1:0]         rhs6_ff [12];
   logic [2:0]               sep_ref_in;
   logic [2:0]               sep_ref_ff;

   always_comb begin
      int i1;
      int i2;
      for (int i = 0; i < 3; i++) begin
         sep_ref_in[i] = lhs5_ff[i] > rhs5_ff[i];
         s_in[i] = S_W'(tr_ff[0][0][i]) + S_W'(tr_ff[1][1][i]) + S_W'(tr_ff[2][2][i]);
      end
      for (int i = 0; i < 3; i++) begin
         i1 = (i == 2) ? 0 : i + 1;
         i2 = (i == 0) ? 2 : i - 1;
         for (int j = 0; j < 3; j++) begin
            s_in[3+3*i+j] = S_W'(tr_ff[i2][i1][j]) - S_W'(tr_ff[i1][i2][j]);
         end
      end
   end

   // stage 7: |s| against radius
   logic                     v7_ff;
   logic [NUM_AXES-1:0]      sep_in;
   logic [NUM_AXES-1:0]      sep_ff;

   always_comb begin
      logic [CMP_W-1:0] smag;
      smag = '0;
      sep_in[2:0] = sep_ref_ff;
      for (int n = 0; n < 12; n++) begin
         smag = s_ff[n][S_W-1] ? CMP_W'($unsigned(-s_ff[n])) : CMP_W'($unsigned(s_ff[n]));
         sep_in[3+n] = smag > rhs6_ff[n];
      end
   end

   // stage 8: result
   logic rsp_valid_ff;
   logic rsp_overlaps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v4_ff        <= rot.valid;
         v5_ff        <= v4_ff;
         v6_ff        <= v5_ff;
         v7_ff        <= v6_ff;
         rsp_valid_ff <= v7_ff;
      end
   end

   always_ff @(posedge clock) begin
      ph_ff      <= ph_in;
      pl_ff      <= pl_in;
      rhs4_ff    <= rhs_in;
      lhs4_ff    <= lhs_in;
      tr_ff      <= tr_in;
      rhs5_ff    <= rhs4_ff;
      lhs5_ff    <= lhs4_ff;
      s_ff       <= s_in;
      sep_ref_ff <= sep_ref_in;
      for (int n = 0; n < 12; n++) begin
         rhs6_ff[n] <= rhs5_ff[3+n];
      end
      sep_ff          <= sep_in;
      rsp_overlaps_ff <= ~(|sep_ff);
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_overlaps = rsp_overlaps_ff;

endmodule

### rtl/obbot_checker.sv
// ----------------------------------------------------------------------------
// obbot_checker
// Port-level checks for the overlap test, bound to the top level.
// ----------------------------------------------------------------------------
module obbot_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic                          csr_psel,
   input logic                          csr_penable,
   input logic                          csr_pwrite,
   input logic [obbot_pkg::CSR_AW-1:0]  csr_paddr,
   input logic [obbot_pkg::CSR_DW-1:0]  csr_pwdata,
   input logic [obbot_pkg::CSR_DW-1:0]  csr_prdata,
   input logic                          csr_pready
);
   import obbot_pkg::*;

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   // every result traces back to a command taken earlier
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("result without a matching command");

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");

   // epsilon read back right after a write transfer returns the written value
   a_slack_readback: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(csr_psel && csr_penable && csr_pwrite)
       && $past(csr_paddr[5:3]) == REG_SLACK
       && csr_psel && !csr_pwrite && csr_paddr[5:3] == REG_SLACK)
      |-> csr_prdata[SLACK_W-1:0] == $past(csr_pwdata[SLACK_W-1:0]))
      else $error("slack readback mismatch");

endmodule

bind obb_obb_overlap_test_top obbot_checker u_checker (.*);
